// File: design/wpcm_pkg.sv
// Package for the wildcard pattern capture matcher.
// Holds character codes, mode and state types and the controller/datapath structs.
// No dependencies.
package wpcm_pkg;

  localparam int unsigned PatMaxDefault = 32;
  localparam int unsigned StrMaxDefault = 1024;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned PatIdxW = 6;

  localparam logic [CfgIdxW-1:0] CfgPat0 = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgPat1 = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgPat2 = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPat3 = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPatLen = 3'd4;

  localparam logic [7:0] ChBar = 8'h7c;
  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChStar = 8'h2a;
  localparam logic [7:0] ChHash = 8'h23;
  localparam logic [7:0] ChBackslash = 8'h5c;
  localparam logic [7:0] ChComma = 8'h2c;
  localparam logic [7:0] ChLParen = 8'h28;
  localparam logic [7:0] ChRParen = 8'h29;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChLowerL = 8'h6c;
  localparam logic [7:0] ChUpperL = 8'h4c;
  localparam logic [7:0] ChZero = 8'h30;
  localparam logic [7:0] ChNine = 8'h39;

  typedef enum logic [1:0] {
    ModeLit = 2'd0,
    ModeRun = 2'd1,
    ModeNum = 2'd2
  } mode_e;

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StChk  = 6'b000010,
    StStep = 6'b000100,
    StEnd  = 6'b001000,
    StFin  = 6'b010000,
    StPass = 6'b100000
  } state_e;

  typedef struct packed {
    logic load;
    logic overflow;
    logic skip;
    logic step;
    logic close;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic has_char;
    logic last;
    logic full;
    logic failed;
    logic done;
  } sts_t;

endpackage

// File: design/wpcm_if.sv
// Stream interfaces for the matcher: one for text beats, one for result beats.
// Depends on nothing.
interface wpcm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;
  modport source (output valid, ch, has_char, last, input ready);
  modport sink (input valid, ch, has_char, last, output ready);
endinterface

interface wpcm_out_if;
  logic               valid;
  logic               ready;
  logic               match_ok;
  logic               capture_seen;
  logic [9:0]         capture_start;
  logic [10:0]        capture_length;
  logic               number_ok;
  logic signed [31:0] number_value;
  logic               line_too_long;
  modport source (output valid, match_ok, capture_seen, capture_start, capture_length,
                  number_ok, number_value, line_too_long, input ready);
  modport sink (input valid, match_ok, capture_seen, capture_start, capture_length,
                number_ok, number_value, line_too_long, output ready);
endinterface

// File: design/wpcm_ctrl.sv
// Sequencer for the matcher: walks each beat through check, step and line-end phases.
// Depends on wpcm_pkg.
module wpcm_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  wpcm_pkg::sts_t  sts_i,
  output wpcm_pkg::cmd_t  cmd_o
);
  import wpcm_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == StIdle);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StChk;
        end
      end
      StChk: begin
        if (!sts_i.has_char) begin
          state_d = sts_i.last ? StEnd : StIdle;
        end else if (sts_i.full) begin
          cmd_o.overflow = 1'b1;
          state_d        = sts_i.last ? StEnd : StIdle;
        end else if (sts_i.failed) begin
          cmd_o.skip = 1'b1;
          state_d    = sts_i.last ? StEnd : StIdle;
        end else begin
          state_d = StStep;
        end
      end
      StStep: begin
        cmd_o.step = 1'b1;
        if (sts_i.done) state_d = sts_i.last ? StEnd : StIdle;
      end
      StEnd: begin
        cmd_o.close = 1'b1;
        state_d     = StFin;
      end
      StFin: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StPass;
        end
      end
      StPass: begin
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// File: design/wpcm_datapath.sv
// Datapath for the matcher: pattern store, line state, number parser, result register.
// Depends on wpcm_pkg.
module wpcm_datapath #(
  parameter int unsigned MAX_PATTERN = wpcm_pkg::PatMaxDefault,
  parameter int unsigned MAX_STRING  = wpcm_pkg::StrMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  wpcm_pkg::cmd_t                cmd_i,
  output wpcm_pkg::sts_t                sts_o,
  input  logic [7:0]                    ch_i,
  input  logic                          has_char_i,
  input  logic                          last_i,
  input  logic                          cfg_we_i,
  input  logic [wpcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wpcm_pkg::CfgDataW-1:0] cfg_data_i,
  output logic                          match_ok_o,
  output logic                          capture_seen_o,
  output logic [9:0]                    capture_start_o,
  output logic [10:0]                   capture_length_o,
  output logic                          number_ok_o,
  output logic signed [31:0]            number_value_o,
  output logic                          line_too_long_o
);
  import wpcm_pkg::*;

  localparam int unsigned PW = $clog2(MAX_STRING + 1);
  localparam int unsigned EW = (PW > 11) ? PW : 11;

  logic [3:0][CfgDataW-1:0] pat_q;
  logic [PatIdxW-1:0]       plen_q;
  logic [7:0]               c_q;
  logic                     has_q, last_q;

  logic [PatIdxW-1:0] idx_q, idx_d;
  mode_e              mode_q, mode_d;
  logic               early_q, early_d, failed_q, failed_d, esc_q, esc_d;
  logic [PW-1:0]      pos_q, pos_d, rb_q, rb_d;
  logic               cap_q, cap_d, taken_q, taken_d, too_long_q, too_long_d;
  logic [9:0]         lcs_q, lcs_d;
  logic [10:0]        lcl_q, lcl_d;
  logic [31:0]        acc_q, acc_d;
  logic               neg_q, neg_d, bad_q, bad_d, suf_q, suf_d;
  logic               done;

  logic [PatIdxW-1:0] n;
  logic [7:0]         x;
  logic [EW-1:0]      diff_ext, rb_ext;
  logic               c_delim, x_delim, c_digit, at_begin;
  logic               ok, num_ok;

  assign n = (plen_q > PatIdxW'(MAX_PATTERN)) ? PatIdxW'(MAX_PATTERN) : plen_q;
  assign x = pat_q[idx_q[4:3]][idx_q[2:0]*8 +: 8];
  assign c_delim = (c_q == ChComma) || (c_q == ChLParen) || (c_q == ChRParen);
  assign x_delim = (x == ChComma) || (x == ChLParen) || (x == ChRParen);
  assign c_digit = (c_q >= ChZero) && (c_q <= ChNine);
  assign at_begin = (pos_q == rb_q);
  assign diff_ext = EW'(pos_q - rb_q);
  assign rb_ext = EW'(rb_q);

  assign ok = !failed_q && ((idx_q >= n) || (x == ChBar) || early_q);
  assign num_ok = ok && taken_q && !bad_q && !(neg_q && (lcl_q == 11'd1));

  assign sts_o.has_char = has_q;
  assign sts_o.last     = last_q;
  assign sts_o.full     = (pos_q >= PW'(MAX_STRING));
  assign sts_o.failed   = failed_q;
  assign sts_o.done     = done;

  always_comb begin
    idx_d = idx_q; mode_d = mode_q; early_d = early_q; failed_d = failed_q;
    esc_d = esc_q; pos_d = pos_q; rb_d = rb_q; cap_d = cap_q; taken_d = taken_q;
    too_long_d = too_long_q; lcs_d = lcs_q; lcl_d = lcl_q; acc_d = acc_q;
    neg_d = neg_q; bad_d = bad_q; suf_d = suf_q;
    done = 1'b0;
    if (cmd_i.overflow) begin
      too_long_d = 1'b1;
      failed_d   = 1'b1;
    end
    if (cmd_i.skip) pos_d = pos_q + 1'b1;
    if (cmd_i.step) begin
      unique case (mode_q)
        ModeRun: begin
          if (!c_delim && (c_q != ChHash)) begin
            done = 1'b1;
            if (cap_q) begin
              if (at_begin && (c_q == ChMinus)) neg_d = 1'b1;
              else if (suf_q) bad_d = 1'b1;
              else if (c_digit) acc_d = (acc_q << 3) + (acc_q << 1) + 32'(c_q - ChZero);
              else if ((c_q == ChLowerL) || (c_q == ChUpperL)) suf_d = 1'b1;
              else bad_d = 1'b1;
            end
          end else if (at_begin) begin
            failed_d = 1'b1;
            done     = 1'b1;
          end else begin
            // close the run and look at the next element
            if (cap_q) begin
              lcs_d   = rb_ext[9:0];
              lcl_d   = diff_ext[10:0];
              taken_d = 1'b1;
            end
            idx_d  = idx_q + 1'b1;
            mode_d = ModeLit;
          end
        end
        ModeNum: begin
          if (c_digit) done = 1'b1;
          else if (at_begin) begin
            failed_d = 1'b1;
            done     = 1'b1;
          end else begin
            idx_d  = idx_q + 1'b1;
            mode_d = ModeLit;
          end
        end
        default: begin
          if (esc_q) begin
            esc_d = 1'b0;
            done  = 1'b1;
            if (c_q == x) idx_d = idx_q + 1'b1;
            else failed_d = 1'b1;
          end else if (idx_q >= n) begin
            failed_d = 1'b1;
            done     = 1'b1;
          end else if (x_delim) begin
            done = 1'b1;
            if (c_delim) idx_d = idx_q + 1'b1;
            else failed_d = 1'b1;
          end else if ((x == ChPercent) || (x == ChStar)) begin
            mode_d = ModeRun;
            rb_d   = pos_q;
            cap_d  = (x == ChPercent);
            if (x == ChPercent) begin
              acc_d = '0; neg_d = 1'b0; bad_d = 1'b0; suf_d = 1'b0;
            end
          end else if (x == ChHash) begin
            mode_d = ModeNum;
            if (c_q == ChMinus) begin
              rb_d = pos_q + 1'b1;
              done = 1'b1;
            end else begin
              rb_d = pos_q;
            end
          end else if (x == ChBar) begin
            early_d = 1'b1;
            idx_d   = idx_q + 1'b1;
          end else if (x == ChBackslash) begin
            idx_d = idx_q + 1'b1;
            if ((idx_q + 1'b1) >= n) begin
              failed_d = 1'b1;
              done     = 1'b1;
            end else begin
              esc_d = 1'b1;
            end
          end else begin
            done = 1'b1;
            if (c_q == x) idx_d = idx_q + 1'b1;
            else failed_d = 1'b1;
          end
        end
      endcase
      if (done) pos_d = pos_q + 1'b1;
    end
    if (cmd_i.close && !failed_q) begin
      if (mode_q == ModeRun) begin
        if (at_begin) failed_d = 1'b1;
        else begin
          if (cap_q) begin
            lcs_d   = rb_ext[9:0];
            lcl_d   = diff_ext[10:0];
            taken_d = 1'b1;
          end
          idx_d  = idx_q + 1'b1;
          mode_d = ModeLit;
        end
      end else if (mode_q == ModeNum) begin
        if (at_begin) failed_d = 1'b1;
        else begin
          idx_d  = idx_q + 1'b1;
          mode_d = ModeLit;
        end
      end
    end
    if (cmd_i.finish) begin
      // drop all line state, keep the pattern
      idx_d = '0; mode_d = ModeLit; early_d = 1'b0; failed_d = 1'b0; esc_d = 1'b0;
      pos_d = '0; rb_d = '0; cap_d = 1'b0; taken_d = 1'b0; too_long_d = 1'b0;
      lcs_d = '0; lcl_d = '0; acc_d = '0; neg_d = 1'b0; bad_d = 1'b0; suf_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0; plen_q <= '0;
      idx_q <= '0; mode_q <= ModeLit; early_q <= 1'b0; failed_q <= 1'b0; esc_q <= 1'b0;
      pos_q <= '0; rb_q <= '0; cap_q <= 1'b0; taken_q <= 1'b0; too_long_q <= 1'b0;
      lcs_q <= '0; lcl_q <= '0; acc_q <= '0; neg_q <= 1'b0; bad_q <= 1'b0; suf_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CfgPat0:   pat_q[0] <= cfg_data_i;
          CfgPat1:   pat_q[1] <= cfg_data_i;
          CfgPat2:   pat_q[2] <= cfg_data_i;
          CfgPat3:   pat_q[3] <= cfg_data_i;
          CfgPatLen: plen_q <= cfg_data_i[PatIdxW-1:0];
          default: ;
        endcase
      end
      idx_q <= idx_d; mode_q <= mode_d; early_q <= early_d; failed_q <= failed_d;
      esc_q <= esc_d; pos_q <= pos_d; rb_q <= rb_d; cap_q <= cap_d; taken_q <= taken_d;
      too_long_q <= too_long_d; lcs_q <= lcs_d; lcl_q <= lcl_d; acc_q <= acc_d;
      neg_q <= neg_d; bad_q <= bad_d; suf_q <= suf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      c_q   <= ch_i;
      has_q <= has_char_i;
      last_q <= last_i;
    end
    if (cmd_i.finish) begin
      match_ok_o       <= ok;
      capture_seen_o   <= taken_q;
      capture_start_o  <= lcs_q;
      capture_length_o <= lcl_q;
      number_ok_o      <= num_ok;
      number_value_o   <= num_ok ? (neg_q ? -acc_q : acc_q) : 32'sd0;
      line_too_long_o  <= too_long_q;
    end
  end

endmodule

// File: design/wildcard_pattern_capture_matcher.sv
// Top level of the wildcard pattern capture matcher.
// Depends on wpcm_pkg, wpcm_if, wpcm_ctrl and wpcm_datapath.
//
//  channel  | dir | handshake           | payload
//  ---------+-----+---------------------+------------------------------------------
//  in_i     | in  | valid/ready         | ch, has_char, last
//  out_o    | out | valid/ready         | match_ok, capture fields, number, too_long
//  cfg      | in  | cfg_we_i, no ready  | cfg_idx_i, cfg_data_i (64 bits)
//
// A text beat is loaded, checked, then stepped through the single pattern-walk unit until
// the character is consumed; a beat with no character, or on a failed or full line, skips the steps.
// A final beat adds line-end closing and the result load.
// Reset clears all line state, the pattern and the result valid.
// A waiting result does not block input; only the next result load waits for it.
module wildcard_pattern_capture_matcher #(
  parameter int unsigned MAX_PATTERN = wpcm_pkg::PatMaxDefault,
  parameter int unsigned MAX_STRING  = wpcm_pkg::StrMaxDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  wpcm_in_if.sink                       in_i,
  wpcm_out_if.source                    out_o,
  input  logic                          cfg_we_i,
  input  logic [wpcm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wpcm_pkg::CfgDataW-1:0] cfg_data_i
);
  import wpcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequence each beat through its phases
  wpcm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // hold pattern, line state and the result register
  wpcm_datapath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_STRING  (MAX_STRING)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .ch_i             (in_i.ch),
    .has_char_i       (in_i.has_char),
    .last_i           (in_i.last),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .match_ok_o       (out_o.match_ok),
    .capture_seen_o   (out_o.capture_seen),
    .capture_start_o  (out_o.capture_start),
    .capture_length_o (out_o.capture_length),
    .number_ok_o      (out_o.number_ok),
    .number_value_o   (out_o.number_value),
    .line_too_long_o  (out_o.line_too_long)
  );

  a_num_needs_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.number_ok || out_o.match_ok)) else $error("number without match");

  a_num_needs_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.number_ok || out_o.capture_seen)) else $error("number without capture");

  a_long_fails: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (!out_o.line_too_long || !out_o.match_ok)) else $error("long line matched");

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready) else $error("second beat taken at once");

endmodule

// File: tb/wpcm_tb_pkg.sv
`timescale 1ns / 1ps
// Line matcher for the wildcard pattern capture matcher testbench.
// Computes the result beat for a stored pattern and a text line; depends on wpcm_pkg.
package wpcm_tb_pkg;
  import wpcm_pkg::*;

  typedef struct packed {
    logic        match_ok;
    logic        capture_seen;
    logic [9:0]  capture_start;
    logic [10:0] capture_length;
    logic        number_ok;
    logic [31:0] number_value;
    logic        line_too_long;
  } line_result_t;

  localparam int unsigned LineMax = StrMaxDefault;
  localparam int unsigned PatMax = PatMaxDefault;

  function automatic bit is_delim(logic [7:0] c);
    return c == ChComma || c == ChLParen || c == ChRParen;
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= ChZero && c <= ChNine;
  endfunction

  // Whole-line matcher: walks the pattern greedily, exactly as the block does.
  class line_matcher;
    logic [63:0] pat_word [4];
    logic [5:0]  pat_len_reg;
    int unsigned pidx, run_begin, pos, acc, max_steps;
    mode_e       mode;
    bit          early_ok, failed, run_cap, cap_taken, neg, bad, suf, too_long;
    int unsigned cap_start, cap_len;

    function void clear_line();
      pidx = 0; mode = ModeLit; early_ok = 0; failed = 0; pos = 0; run_begin = 0;
      run_cap = 0; cap_start = 0; cap_len = 0; cap_taken = 0; acc = 0;
      neg = 0; bad = 0; suf = 0; too_long = 0;
    endfunction

    function void reset_all();
      foreach (pat_word[i]) pat_word[i] = '0;
      pat_len_reg = '0;
      clear_line();
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] data);
      if (idx <= CfgPat3) pat_word[idx[1:0]] = data;
      else if (idx == CfgPatLen) pat_len_reg = data[5:0];
    endfunction

    function int unsigned plen();
      return pat_len_reg > PatMax ? PatMax : pat_len_reg;
    endfunction

    function logic [7:0] pchar(int unsigned p);
      return pat_word[(p >> 3) & 3][(p & 7) * 8 +: 8];
    endfunction

    function void feed_number(logic [7:0] c, int unsigned idx);
      if (idx == 0 && c == ChMinus) neg = 1;
      else if (suf) bad = 1;
      else if (is_digit(c)) acc = acc * 10 + (c - ChZero);
      else if (c == ChLowerL || c == ChUpperL) suf = 1;
      else bad = 1;
    endfunction

    function void close_run();
      if (run_cap) begin
        cap_start = run_begin & 'h3ff;
        cap_len = (pos - run_begin) & 'h7ff;
        cap_taken = 1;
      end
      pidx++;
      mode = ModeLit;
    endfunction

    function void consume(logic [7:0] c);
      logic [7:0] x;
      for (int g = 0; g < 3 * PatMax + 4; g++) begin
        if (mode == ModeRun) begin
          if (!is_delim(c) && c != ChHash) begin
            if (run_cap) feed_number(c, pos - run_begin);
            return;
          end
          if (pos == run_begin) begin failed = 1; return; end
          close_run();
          continue;
        end
        if (mode == ModeNum) begin
          if (is_digit(c)) return;
          if (pos == run_begin) begin failed = 1; return; end
          pidx++; mode = ModeLit;
          continue;
        end
        if (pidx >= plen()) begin failed = 1; return; end
        x = pchar(pidx);
        if (is_delim(x)) begin
          if (is_delim(c)) pidx++; else failed = 1;
          return;
        end
        if (x == ChPercent || x == ChStar) begin
          mode = ModeRun; run_begin = pos; run_cap = (x == ChPercent);
          if (run_cap) begin acc = 0; neg = 0; bad = 0; suf = 0; end
          continue;
        end
        if (x == ChHash) begin
          mode = ModeNum;
          if (c == ChMinus) begin run_begin = pos + 1; return; end
          run_begin = pos;
          continue;
        end
        if (x == ChBar) begin early_ok = 1; pidx++; continue; end
        if (x == ChBackslash) begin
          pidx++;
          if (pidx >= plen()) begin failed = 1; return; end
          x = pchar(pidx);
        end
        if (c == x) pidx++; else failed = 1;
        return;
      end
      failed = 1;
    endfunction

    // Returns 1 and fills res when the beat ends the line.
    function bit take_beat(logic [7:0] c, bit has, bit fin, output line_result_t res);
      bit ok;
      res = '0;
      if (has) begin
        if (pos >= LineMax) begin too_long = 1; failed = 1; end
        else begin
          if (!failed) consume(c);
          pos++;
        end
      end
      if (!fin) return 0;
      if (!failed) begin
        if (mode == ModeRun) begin
          if (pos == run_begin) failed = 1; else close_run();
        end else if (mode == ModeNum) begin
          if (pos == run_begin) failed = 1;
          else begin pidx++; mode = ModeLit; end
        end
      end
      ok = 0;
      if (!failed) begin
        if (pidx >= plen()) ok = 1;
        else begin
          if (pchar(pidx) == ChBar) early_ok = 1;
          ok = early_ok;
        end
      end
      res.match_ok = ok;
      res.capture_seen = cap_taken;
      res.capture_start = cap_start[9:0];
      res.capture_length = cap_len[10:0];
      res.line_too_long = too_long;
      if (ok && cap_taken && !bad && !(neg && cap_len == 1)) begin
        res.number_ok = 1;
        res.number_value = neg ? 32'(0 - acc) : 32'(acc);
      end
      clear_line();
      return 1;
    endfunction
  endclass
endpackage

// File: tb/wildcard_pattern_capture_matcher_test.sv
`timescale 1ns / 1ps
// Top of the wildcard pattern capture matcher testbench: clock, reset, stimulus,
// result checking. Depends on wpcm_pkg, wpcm_if, wpcm_tb_pkg and the matcher RTL.
module wildcard_pattern_capture_matcher_test;
  import wpcm_pkg::*;
  import wpcm_tb_pkg::*;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  wpcm_in_if  text_if ();
  wpcm_out_if res_if ();

  wildcard_pattern_capture_matcher i_dut (
    .clk_i, .rst_ni, .in_i(text_if), .out_o(res_if), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  line_matcher   matcher;
  line_result_t  pending_results [$];
  int unsigned   n_errors, n_beats, n_lines, n_matched, n_numbers;
  bit            quiet;  // no idling on either side near the end of the run

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Hard limit: covers about 1700 beats with their gaps, plus long lines and stalls.
  initial begin
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    text_if.valid = 0; text_if.ch = '0; text_if.has_char = 0; text_if.last = 0;
    res_if.ready = 0;
  end

  // Result side: ready idles in bursts; check every accepted beat.
  initial begin
    int unsigned hold;
    line_result_t got, want;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got = '{res_if.match_ok, res_if.capture_seen, res_if.capture_start,
                res_if.capture_length, res_if.number_ok, res_if.number_value,
                res_if.line_too_long};
        if (pending_results.size() == 0) begin
          $error("result beat with no line outstanding");
          n_errors++;
        end else begin
          want = pending_results.pop_front();
          if (got.match_ok !== want.match_ok) begin
            $error("match_ok: expected %0d, got %0d", want.match_ok, got.match_ok); n_errors++;
          end
          if (got.capture_seen !== want.capture_seen) begin
            $error("capture_seen: expected %0d, got %0d", want.capture_seen, got.capture_seen);
            n_errors++;
          end
          if (got.capture_start !== want.capture_start) begin
            $error("capture_start: expected %0d, got %0d", want.capture_start,
                   got.capture_start); n_errors++;
          end
          if (got.capture_length !== want.capture_length) begin
            $error("capture_length: expected %0d, got %0d", want.capture_length,
                   got.capture_length); n_errors++;
          end
          if (got.number_ok !== want.number_ok) begin
            $error("number_ok: expected %0d, got %0d", want.number_ok, got.number_ok);
            n_errors++;
          end
          if (got.number_value !== want.number_value) begin
            $error("number_value: expected %0d, got %0d", $signed(want.number_value),
                   $signed(got.number_value)); n_errors++;
          end
          if (got.line_too_long !== want.line_too_long) begin
            $error("line_too_long: expected %0d, got %0d", want.line_too_long,
                   got.line_too_long); n_errors++;
          end
        end
      end
      // Decide ready for the next edge, with random idle bursts.
      if (hold > 0) hold--;
      else if (!quiet && $urandom_range(0, 5) == 0) hold = $urandom_range(1, 7);
      res_if.ready <= rst_ni && (hold == 0);
    end
  end

  // Drive one text beat, predict it, and wait for acceptance.
  task automatic send_beat(logic [7:0] c, bit has, bit fin);
    line_result_t r;
    int unsigned gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      text_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    text_if.valid <= 1; text_if.ch <= c; text_if.has_char <= has; text_if.last <= fin;
    @(posedge clk_i);
    while (!text_if.ready) @(posedge clk_i);
    if (matcher.take_beat(c, has, fin, r)) begin
      pending_results.push_back(r);
      n_lines++;
      if (r.match_ok) n_matched++;
      if (r.number_ok) n_numbers++;
    end
    n_beats++;
  endtask

  task automatic send_line(string s);
    if (s.len() == 0) send_beat(8'($urandom_range(0, 255)), 0, 1);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1, i == s.len() - 1);
  endtask

  // Write one register while the block is idle: wait for every result plus slack.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [63:0] data);
    text_if.valid <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i <= 1; cfg_idx_i <= idx; cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 0;
    matcher.write_reg(idx, data);
  endtask

  task automatic load_pattern(string p, int len);
    logic [63:0] w [4];
    foreach (w[i]) w[i] = {$urandom, $urandom};  // bytes beyond the length are noise
    for (int i = 0; i < p.len() && i < 32; i++) w[i / 8][(i % 8) * 8 +: 8] = p[i];
    write_reg(CfgPat0, w[0]); write_reg(CfgPat1, w[1]);
    write_reg(CfgPat2, w[2]); write_reg(CfgPat3, w[3]);
    write_reg(CfgPatLen, 6'(len));
  endtask

  // Pick one character: mostly ones that the pattern elements care about.
  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 9))
      0: return ChComma;
      1: return $urandom_range(0, 1) ? ChLParen : ChRParen;
      2: return ChMinus;
      3: return ChHash;
      4: return $urandom_range(0, 1) ? ChLowerL : ChUpperL;
      5, 6: return 8'($urandom_range(ChZero, ChNine));
      7: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range("a", "e"));
    endcase
  endfunction

  // Build a line that should mostly follow the pattern, with random breakage.
  function automatic string shaped_line(string p, int len);
    string s;
    int i;
    s = ""; i = 0;
    while (i < len) begin
      logic [7:0] x;
      x = p[i];
      if ($urandom_range(0, 15) == 0) s = {s, string'(pick_char())};
      if (x == ChPercent || x == ChStar) begin
        if ($urandom_range(0, 2) == 0) s = {s, "-"};
        repeat ($urandom_range(1, 4)) s = {s, string'(8'($urandom_range(ChZero, ChNine)))};
        if ($urandom_range(0, 3) == 0) s = {s, $urandom_range(0, 1) ? "l" : "L"};
        if ($urandom_range(0, 5) == 0) s = {s, "x"};
      end else if (x == ChHash) begin
        if ($urandom_range(0, 2) == 0) s = {s, "-"};
        repeat ($urandom_range(1, 3)) s = {s, string'(8'($urandom_range(ChZero, ChNine)))};
      end else if (is_delim(x)) s = {s, string'(ChComma + (ChLParen - ChComma) *
                                                8'($urandom_range(0, 1)))};
      else if (x == ChBar) begin
        if ($urandom_range(0, 2) == 0) return s;  // stop early after a bar
      end else if (x == ChBackslash) begin
        i++;
        if (i < len) s = {s, string'(p[i])};
      end else s = {s, string'(x)};
      i++;
    end
    if ($urandom_range(0, 9) == 0) s = {s, string'(pick_char())};
    return s;
  endfunction

  function automatic string random_pattern(int len);
    string p;
    logic [7:0] opts [10];
    opts = '{ChPercent, ChStar, ChHash, ChBar, ChBackslash, ChComma, ChLParen,
             ChRParen, "a", "b"};
    p = "";
    for (int i = 0; i < len; i++) begin
      if (i > 0 && (p[i - 1] == ChPercent || p[i - 1] == ChStar))
        p = {p, string'(opts[5 + $urandom_range(0, 2)])};  // delimiter ends a run
      else p = {p, string'(opts[$urandom_range(0, 9)])};
    end
    return p;
  endfunction

  // Directed table: pattern, line, and expected verdict/number where obvious.
  typedef struct {
    string pat;
    string txt;
    bit    check_fixed;
    bit    want_ok;
    bit    want_num;
    int    want_val;
  } case_row_t;

  case_row_t dir_rows [$] = '{
    '{"", "", 1, 1, 0, 0},
    '{"", "a", 1, 0, 0, 0},
    '{"abc", "abc", 1, 1, 0, 0},
    '{"abc", "ab", 1, 0, 0, 0},
    '{"ab|c", "ab", 1, 1, 0, 0},
    '{"f(%)", "f(42)", 1, 1, 1, 42},
    '{"f(%)", "f,-7L)", 1, 1, 1, -7},
    '{"f(%)", "f(-)", 1, 1, 0, 0},
    '{"f(%)", "f(4l2)", 1, 1, 0, 0},
    '{"f(%)", "f(4294967297)", 1, 1, 1, 1},
    '{"#,*", "-12,xy", 1, 1, 0, 0},
    '{"#", "-", 1, 0, 0, 0},
    '{"a\\%", "a%", 1, 1, 0, 0},
    '{"a\\", "a", 1, 0, 0, 0},
    '{"a\\", "ab", 1, 0, 0, 0},
    '{"%#", "12#5", 0, 0, 0, 0},
    '{"*(%)|,%", "g(9)", 0, 0, 0, 0},
    '{"%,%", "5,x6", 0, 0, 0, 0},
    '{"(%)", "()", 1, 0, 0, 0}
  };

  initial begin
    line_result_t want;
    string p, s;
    int plen;
    matcher = new();
    matcher.reset_all();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // After reset the pattern is empty: an empty line matches.
    send_line("");

    // Walk the directed table; fixed verdicts are also checked against the predictor.
    foreach (dir_rows[i]) begin
      load_pattern(dir_rows[i].pat, dir_rows[i].pat.len());
      send_line(dir_rows[i].txt);
      if (dir_rows[i].check_fixed) begin
        want = pending_results[$];
        if (want.match_ok != dir_rows[i].want_ok || want.number_ok != dir_rows[i].want_num ||
            (want.number_ok && $signed(want.number_value) != dir_rows[i].want_val)) begin
          $error("row %0d: predicted match_ok %0d number %0d, table says %0d %0d", i,
                 want.match_ok, want.number_ok, dir_rows[i].want_ok, dir_rows[i].want_num);
          n_errors++;
        end
      end
    end

    // Oversized length saturates; a line past the string limit is flagged.
    load_pattern("*,ab", 63);
    send_beat("q", 0, 0);  // no character, not last: nothing happens
    for (int i = 0; i < LineMax + 3; i++) send_beat("z", 1, i == LineMax + 2);

    // Random phases: new pattern each phase, lines shaped after it.
    while (n_beats < 1700) begin
      plen = $urandom_range(0, 7) == 0 ? 32 : $urandom_range(1, 8);
      p = random_pattern(plen);
      load_pattern(p, $urandom_range(0, 9) == 0 ? 32 + $urandom_range(0, 31) : plen);
      repeat ($urandom_range(6, 14)) begin
        if ($urandom_range(0, 7) == 0) begin
          s = "";
          repeat ($urandom_range(0, 6)) s = {s, string'(pick_char())};
        end else s = shaped_line(p, plen);
        if ($urandom_range(0, 9) == 0) send_beat(8'($urandom_range(0, 255)), 0, 0);
        send_line(s);
      end
      if (n_beats > 1500) quiet = 1;
    end

    text_if.valid <= 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Covered %0d text beats in %0d lines: %0d matched, %0d gave a number.",
             n_beats, n_lines, n_matched, n_numbers);
    if (n_errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
